// ===== hw/rtl/dsg_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dsg_pkg
// Shared types, codes and constants of the direct-sum 2D gravity block.
// ============================================================================
package dsg_pkg;

  localparam int MAX_BODIES_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ACC_GUARD      = 8;

  localparam logic [10:0] BODY_COUNT_RST = 11'd0;
  localparam logic [31:0] GRAV_RST       = 32'd65536;
  localparam logic [31:0] SOFT_RST       = 32'd655;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_BODY_COUNT = 2'd0,
    REG_GRAV       = 2'd1,
    REG_SOFT       = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_LATCH,
    T_NEXT,
    T_REQ,
    T_WAIT,
    T_FIN
  } top_state_e;

  typedef enum logic [3:0] {
    P_IDLE,
    P_SQ,
    P_SUM,
    P_NORM,
    P_SQRTS,
    P_SQRT,
    P_PMUL,
    P_DIVS,
    P_DIV,
    P_CMUL,
    P_NORMC,
    P_TMUL,
    P_TERM
  } pair_state_e;

  typedef struct packed {
    logic               op;
    logic [9:0]         body_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        body_mass;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         query_index;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] mass;
  } body_t;

  typedef struct packed {
    logic        valid;
    body_t       body;
    logic [31:0] xi;
    logic [31:0] yi;
  } pair_req_t;

  typedef struct packed {
    logic        valid;
    logic        sat;
    logic [63:0] term_x;
    logic [63:0] term_y;
  } pair_rsp_t;

endpackage

// ===== hw/rtl/direct_sum_gravity_2d.sv =====
`timescale 1ns / 1ps
// ============================================================================
// direct_sum_gravity_2d
// Direct-sum softened 2D gravity over a body store, Q16.16 fixed point.
// ============================================================================
// An item is taken when start is high and busy is low. A load item writes
// one body into the store in that cycle and leaves busy low, so loads can
// follow each other in every cycle. A query item raises busy while it walks
// the store from index zero up to the body count, capped at MaxBodies,
// skipping the queried body. Each other body takes one pass through the
// pairwise unit, whose run time depends on the square root, the reciprocal
// divider and the normalizing shifts; a body whose mass times G is zero
// skips all three. A query latches the queried body's position in T_LATCH,
// then runs T_NEXT, T_REQ and T_WAIT per other body and ends in T_FIN.
// The result sits on res_o for one cycle with res_valid_o high, in the
// cycle after T_FIN, and busy is low in that same cycle. The receiver
// cannot stall; a result must be taken when shown. Reset returns the
// registers to their defaults and ends any query; the store keeps no
// contents guarantee and is not cleared, so a body must be loaded before
// it is used.
// ============================================================================
module direct_sum_gravity_2d import dsg_pkg::*; #(
  parameter int MaxBodies = MAX_BODIES_DEF,
  parameter int FracBits  = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item_i,
  output logic        res_valid_o,
  output out_item_t   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MaxBodies);
  localparam int CW = $clog2(MaxBodies + 1);

  top_state_e state_q, state_d;

  logic [10:0] body_count_q;
  logic [31:0] grav_q, soft_q;
  logic [9:0]  idx_q;
  logic [CW-1:0] j_q;
  logic [31:0] xi_q, yi_q;
  logic [63:0] accx_q, accy_q;
  logic        sat_q;
  logic        res_valid_q;
  out_item_t   res_q;

  logic          accept, cfg_we, idx_ok, is_self, mem_we, mem_re, pair_valid;
  logic [16:0]   idx_ext;
  logic [CW-1:0] n_w;
  logic [AW-1:0] mem_raddr;
  body_t         rdata;
  pair_req_t     req;
  pair_rsp_t     rsp;
  logic [32:0]   fin_x, fin_y;

  function automatic logic [32:0] finish(logic [63:0] acc);
    logic [63:0] mag;
    logic        sat;
    mag = (acc[63] ? 64'd0 - acc : acc) >> ACC_GUARD;
    sat = 1'b0;
    if (acc[63]) begin
      if (mag > 64'h8000_0000) begin
        mag = 64'h8000_0000;
        sat = 1'b1;
      end
      mag = 64'd0 - mag;
    end else if (mag > 64'h7FFF_FFFF) begin
      mag = 64'h7FFF_FFFF;
      sat = 1'b1;
    end
    return {sat, mag[31:0]};
  endfunction

  assign accept  = start && !busy;
  assign busy    = (state_q != T_IDLE);
  assign idx_ext = 17'(item_i.body_index);
  assign idx_ok  = idx_ext < 17'(MaxBodies);
  assign is_self = 17'(j_q) == 17'(idx_q);
  assign n_w     = (17'(body_count_q) > 17'(MaxBodies)) ? CW'(MaxBodies)
                                                        : CW'(body_count_q);

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_count_q <= BODY_COUNT_RST;
      grav_q       <= GRAV_RST;
      soft_q       <= SOFT_RST;
    end else if (cfg_we) begin
      unique case (reg_e'(paddr[3:2]))
        REG_BODY_COUNT: body_count_q <= pwdata[10:0];
        REG_GRAV:       grav_q       <= pwdata;
        REG_SOFT:       soft_q       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_BODY_COUNT: prdata = {21'b0, body_count_q};
      REG_GRAV:       prdata = grav_q;
      REG_SOFT:       prdata = soft_q;
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = j_q[AW-1:0];
    pair_valid = 1'b0;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          if (item_i.op == OP_LOAD) begin
            mem_we = idx_ok;
          end else if (idx_ok) begin
            mem_re    = 1'b1;
            mem_raddr = idx_ext[AW-1:0];
            state_d   = T_LATCH;
          end else begin
            state_d = T_FIN;
          end
        end
      end
      T_LATCH: state_d = T_NEXT;
      T_NEXT: begin
        if (j_q >= n_w) begin
          state_d = T_FIN;
        end else if (!is_self) begin
          mem_re  = 1'b1;
          state_d = T_REQ;
        end
      end
      T_REQ: begin
        pair_valid = 1'b1;
        state_d    = T_WAIT;
      end
      T_WAIT:  if (rsp.valid) state_d = T_NEXT;
      T_FIN:   state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == T_FIN);
    end
  end

  assign fin_x = finish(accx_q);
  assign fin_y = finish(accy_q);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      T_IDLE: begin
        if (accept && item_i.op == OP_QUERY) begin
          idx_q  <= item_i.body_index;
          j_q    <= '0;
          accx_q <= '0;
          accy_q <= '0;
          sat_q  <= 1'b0;
        end
      end
      T_LATCH: begin
        xi_q <= rdata.x;
        yi_q <= rdata.y;
      end
      T_NEXT: begin
        if (j_q < n_w && is_self) begin
          j_q <= j_q + CW'(1);
        end
      end
      T_WAIT: begin
        if (rsp.valid) begin
          accx_q <= accx_q + rsp.term_x;
          accy_q <= accy_q + rsp.term_y;
          sat_q  <= sat_q | rsp.sat;
          j_q    <= j_q + CW'(1);
        end
      end
      T_FIN: begin
        res_q.query_index <= idx_q;
        res_q.acc_x       <= fin_x[31:0];
        res_q.acc_y       <= fin_y[31:0];
        res_q.saturated   <= sat_q | fin_x[32] | fin_y[32];
      end
      default: ;
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  dsg_body_mem #(
    .Depth (MaxBodies)
  ) u_mem (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i ({item_i.pos_x, item_i.pos_y, item_i.body_mass}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  assign req.valid = pair_valid;
  assign req.body  = rdata;
  assign req.xi    = xi_q;
  assign req.yi    = yi_q;

  dsg_pair #(
    .FracBits (FracBits)
  ) u_pair (
    .clk_i,
    .rst_ni,
    .grav_i (grav_q),
    .soft_i (soft_q),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held for more than one cycle");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_i.op == OP_LOAD) |=> !busy)
    else $error("load item raised busy");

  a_rsp_when_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (state_q == T_WAIT))
    else $error("pair response outside of wait state");

  a_res_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(state_q) == T_FIN))
    else $error("result without finished query");

endmodule

// ===== hw/rtl/dsg_body_mem.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dsg_body_mem
// Body store: one synchronous memory with one write and one registered read.
// ============================================================================
module dsg_body_mem import dsg_pkg::*; #(
  parameter int Depth = MAX_BODIES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  body_t                    wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output body_t                    rdata_o
);

  body_t mem_q [Depth];
  body_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/dsg_isqrt.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dsg_isqrt
// Integer square root of a mantissa shifted up by 32, one result bit a cycle.
// ============================================================================
module dsg_isqrt import dsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] m_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] v_q;
  logic [63:0] res_q;
  logic [63:0] bit_q;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= {m_i, 32'b0};
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

// ===== hw/rtl/dsg_recip.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dsg_recip
// Restoring divider for 2^61 over a 32-bit divisor, one quotient bit a cycle.
// ============================================================================
module dsg_recip import dsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] div_i,
  output logic        done_o,
  output logic [32:0] quot_o
);

  localparam logic [31:0] RemInit = 32'd1 << 28;

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] div_q;
  logic [31:0] rem_q;
  logic [32:0] quot_q;
  logic [32:0] rem2;
  logic        fits;

  assign rem2 = {rem_q, 1'b0};
  assign fits = rem2 >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= div_i;
      rem_q  <= RemInit;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? 32'(rem2 - {1'b0, div_q}) : rem2[31:0];
      quot_q <= {quot_q[31:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/dsg_pair.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dsg_pair
// Pairwise interaction unit: one softened gravity term per request.
// ============================================================================
module dsg_pair import dsg_pkg::*; #(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] grav_i,
  input  logic [31:0] soft_i,
  input  pair_req_t   req_i,
  output pair_rsp_t   rsp_o
);

  localparam bit FracOdd = (FracBits % 2) == 1;
  localparam logic signed [11:0] YBias = 12'(77 + 2 * FracBits - ACC_GUARD);

  pair_state_e state_q, state_d;

  logic        negx_q, negy_q;
  logic [31:0] ux_q, uy_q, mass_q;
  logic [63:0] sqx_q, sqy_q, a_q;
  logic [64:0] m_q;
  logic signed [7:0] k_q;
  logic [5:0]  ea_q, sc_q;
  logic [31:0] p_q;
  logic [64:0] cc_q;
  logic [62:0] mx_q, my_q;
  logic        rsp_valid_q;
  logic        rsp_sat_q;
  logic [63:0] rsp_x_q, rsp_y_q;

  logic [32:0] dx, dy;
  logic [63:0] s_w, s_nz;
  logic        m_big, m_small, a_big, cc_big;
  logic        sqrt_done, rcp_done;
  logic [31:0] root;
  logic [32:0] quot;
  logic [63:0] pm_prod;
  logic signed [7:0]  h_w;
  logic signed [11:0] y_w;
  logic [64:0] tx, ty;

  function automatic logic [64:0] make_term(logic [62:0] mag, logic signed [11:0] y,
                                            logic neg);
    logic [46:0] lim;
    logic [46:0] sh;
    logic [62:0] t;
    logic [11:0] ny;
    logic        sat;
    lim = 47'd1 << 46;
    sh  = '0;
    t   = '0;
    ny  = 12'(-y);
    sat = 1'b0;
    if (mag != '0) begin
      if (!y[11]) begin
        if (y > 12'sd46 || mag > {16'b0, lim >> y[5:0]}) begin
          t   = {16'b0, lim};
          sat = 1'b1;
        end else begin
          sh = mag[46:0] << y[5:0];
          t  = {16'b0, sh};
        end
      end else begin
        t = mag >> ny;
      end
    end
    return {sat, neg ? 64'd0 - {1'b0, t} : {1'b0, t}};
  endfunction

  assign dx = {req_i.body.x[31], req_i.body.x} - {req_i.xi[31], req_i.xi};
  assign dy = {req_i.body.y[31], req_i.body.y} - {req_i.yi[31], req_i.yi};

  assign s_w     = (sqx_q >> FracBits) + (sqy_q >> FracBits) + {32'b0, soft_i};
  assign s_nz    = (s_w == '0) ? 64'd1 : s_w;
  assign m_big   = |m_q[64:32];
  assign m_small = (m_q[31:30] == 2'b00);
  assign a_big   = |a_q[63:32];
  assign cc_big  = |cc_q[64:31];
  assign pm_prod = {32'b0, m_q[31:0]} * {32'b0, root};

  assign h_w = (k_q - 8'(FracBits)) >>> 1;
  assign y_w = $signed({6'b0, sc_q}) + $signed({6'b0, ea_q}) - YBias
             - $signed({{4{h_w[7]}}, h_w}) * 12'sd3;
  assign tx  = make_term(mx_q, y_w, negx_q);
  assign ty  = make_term(my_q, y_w, negy_q);

  dsg_isqrt u_isqrt (
    .clk_i,
    .rst_ni,
    .start_i (state_q == P_SQRTS),
    .m_i     (m_q[31:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  dsg_recip u_recip (
    .clk_i,
    .rst_ni,
    .start_i (state_q == P_DIVS),
    .div_i   (p_q),
    .done_o  (rcp_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= P_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= (state_q == P_TERM);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      P_IDLE:  if (req_i.valid) state_d = P_SQ;
      P_SQ:    state_d = P_SUM;
      P_SUM:   state_d = (a_q == '0) ? P_TERM : P_NORM;
      P_NORM:  if (!m_big && !m_small && !a_big) state_d = P_SQRTS;
      P_SQRTS: state_d = P_SQRT;
      P_SQRT:  if (sqrt_done) state_d = P_PMUL;
      P_PMUL:  state_d = P_DIVS;
      P_DIVS:  state_d = P_DIV;
      P_DIV:   if (rcp_done) state_d = P_CMUL;
      P_CMUL:  state_d = P_NORMC;
      P_NORMC: if (!cc_big) state_d = P_TMUL;
      P_TMUL:  state_d = P_TERM;
      P_TERM:  state_d = P_IDLE;
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      P_IDLE: begin
        if (req_i.valid) begin
          negx_q <= dx[32];
          negy_q <= dy[32];
          ux_q   <= dx[32] ? 32'(33'd0 - dx) : dx[31:0];
          uy_q   <= dy[32] ? 32'(33'd0 - dy) : dy[31:0];
          mass_q <= req_i.body.mass;
        end
      end
      P_SQ: begin
        sqx_q <= {32'b0, ux_q} * {32'b0, ux_q};
        sqy_q <= {32'b0, uy_q} * {32'b0, uy_q};
        a_q   <= {32'b0, grav_i} * {32'b0, mass_q};
      end
      P_SUM: begin
        m_q  <= FracOdd ? {s_nz, 1'b0} : {1'b0, s_nz};
        k_q  <= FracOdd ? -8'sd1 : 8'sd0;
        ea_q <= '0;
        mx_q <= '0;
        my_q <= '0;
      end
      P_NORM: begin
        if (m_big) begin
          m_q <= m_q >> 2;
          k_q <= k_q + 8'sd2;
        end else if (m_small) begin
          m_q <= m_q << 2;
          k_q <= k_q - 8'sd2;
        end
        if (a_big) begin
          a_q  <= a_q >> 1;
          ea_q <= ea_q + 6'd1;
        end
      end
      P_PMUL: p_q <= pm_prod[63:32];
      P_CMUL: begin
        cc_q <= {33'b0, a_q[31:0]} * {32'b0, quot};
        sc_q <= '0;
      end
      P_NORMC: begin
        if (cc_big) begin
          cc_q <= cc_q >> 1;
          sc_q <= sc_q + 6'd1;
        end
      end
      P_TMUL: begin
        mx_q <= {31'b0, ux_q} * {32'b0, cc_q[30:0]};
        my_q <= {31'b0, uy_q} * {32'b0, cc_q[30:0]};
      end
      P_TERM: begin
        rsp_sat_q <= tx[64] | ty[64];
        rsp_x_q   <= tx[63:0];
        rsp_y_q   <= ty[63:0];
      end
      default: ;
    endcase
  end

  assign rsp_o = {rsp_valid_q, rsp_sat_q, rsp_x_q, rsp_y_q};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking testbench for the direct-sum 2D gravity block.
// ============================================================================
// Bodies are loaded and queried through the start/busy command port, and
// the three registers are written over APB while the block is idle. A
// scoreboard keeps its own body store and register copies. It works out
// each query's acceleration in the same fixed-point steps as the block, and
// compares every strobed result with the oldest pending expectation.
// ============================================================================
module tb;
  import dsg_pkg::*;

  localparam int          NUM_BODIES  = 1024;
  localparam int          FILL_BODIES = 64;
  localparam int          FRAC        = 16;
  localparam longint      TERM_CLIP   = 64'd1 << 46;
  localparam int          IDLE_LIMIT  = 1000000;
  localparam int          RAND_ITEMS  = 500;
  localparam logic [31:0] POS_MAX     = 32'h7FFFFFFF;
  localparam logic [31:0] POS_MIN     = 32'h80000000;
  localparam logic [31:0] ALL_ONES    = 32'hFFFFFFFF;

  class grav_scoreboard;
    logic [31:0] body_x[NUM_BODIES];
    logic [31:0] body_y[NUM_BODIES];
    logic [31:0] body_m[NUM_BODIES];
    logic [10:0] count;
    logic [31:0] grav;
    logic [31:0] soft_val;
    out_item_t   accel_q[$];
    int          errors;

    function new();
      count    = BODY_COUNT_RST;
      grav     = GRAV_RST;
      soft_val = SOFT_RST;
      errors   = 0;
    endfunction

    function void set_reg(reg_e r, logic [31:0] v);
      case (r)
        REG_BODY_COUNT: count    = v[10:0];
        REG_GRAV:       grav     = v;
        REG_SOFT:       soft_val = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return accel_q.size();
    endfunction

    function int bit_len(longint unsigned v);
      int n;
      n = 0;
      while (v != 0) begin
        v = v >> 1;
        n++;
      end
      return n;
    endfunction

    function longint scale_term(longint unsigned mag, int y, bit neg, inout bit sat);
      longint unsigned t;
      if (mag == 0) return 0;
      if (y >= 0) begin
        if (y >= 47 || mag > (TERM_CLIP >> y)) begin
          t   = TERM_CLIP;
          sat = 1'b1;
        end else begin
          t = mag << y;
        end
      end else begin
        t = (y <= -64) ? 64'd0 : (mag >> (-y));
      end
      return neg ? -longint'(t) : longint'(t);
    endfunction

    function logic [31:0] clip_sum(longint acc, inout bit sat);
      longint unsigned mag;
      mag = (acc < 0 ? longint'(-acc) : acc);
      mag = mag >> ACC_GUARD;
      if (acc < 0) begin
        if (mag > 64'h80000000) begin
          sat = 1'b1;
          mag = 64'h80000000;
        end
        return 32'(-mag);
      end
      if (mag > 64'h7FFFFFFF) begin
        sat = 1'b1;
        mag = 64'h7FFFFFFF;
      end
      return mag[31:0];
    endfunction

    function void note_item(in_item_t it);
      int              n, idx, len, k, h, ea, sc, y;
      longint          xi, yi, dx, dy, accx, accy;
      longint unsigned ux, uy, s, m, v, res, bitv, p, rcp, a, cc;
      bit              sat;
      out_item_t       e;
      idx = it.body_index;
      if (it.op == OP_LOAD) begin
        body_x[idx] = it.pos_x;
        body_y[idx] = it.pos_y;
        body_m[idx] = it.body_mass;
        return;
      end
      n    = (count > NUM_BODIES) ? NUM_BODIES : count;
      accx = 0;
      accy = 0;
      sat  = 1'b0;
      xi   = longint'($signed(body_x[idx]));
      yi   = longint'($signed(body_y[idx]));
      for (int j = 0; j < n; j++) begin
        if (j == idx) continue;
        dx = longint'($signed(body_x[j])) - xi;
        dy = longint'($signed(body_y[j])) - yi;
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        s  = ((ux * ux) >> FRAC) + ((uy * uy) >> FRAC) + {32'd0, soft_val};
        if (s == 0) s = 1;
        len = bit_len(s);
        k   = (((len + FRAC) & 1) == 0) ? len - 32 : len - 31;
        m   = (k >= 0) ? (s >> k) : (s << (-k));
        h   = (k - FRAC) / 2;
        v    = m << 32;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
          if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
          end else begin
            res = res >> 1;
          end
          bitv = bitv >> 2;
        end
        p   = (m * res) >> 32;
        rcp = (64'd1 << 61) / p;
        a   = {32'd0, grav} * {32'd0, body_m[j]};
        if (a == 0) continue;
        len = bit_len(a);
        ea  = (len > 32) ? len - 32 : 0;
        a   = a >> ea;
        cc  = a * rcp;
        len = bit_len(cc);
        sc  = (len > 31) ? len - 31 : 0;
        cc  = cc >> sc;
        y   = sc + ea - 77 - 2 * FRAC - 3 * h + ACC_GUARD;
        accx += scale_term(ux * cc, y, dx < 0, sat);
        accy += scale_term(uy * cc, y, dy < 0, sat);
      end
      e.query_index = it.body_index;
      e.acc_x       = clip_sum(accx, sat);
      e.acc_y       = clip_sum(accy, sat);
      e.saturated   = sat;
      accel_q.push_back(e);
    endfunction

    function void check_result(out_item_t r);
      out_item_t e;
      if (accel_q.size() == 0) begin
        $display("%0t: result with no query pending, actual %h", $time, r);
        errors++;
        return;
      end
      e = accel_q.pop_front();
      if (r.query_index !== e.query_index) begin
        $display("%0t: query_index expected %0d actual %0d", $time, e.query_index,
                 r.query_index);
        errors++;
      end
      if (r.acc_x !== e.acc_x) begin
        $display("%0t: acc_x expected %h actual %h", $time, e.acc_x, r.acc_x);
        errors++;
      end
      if (r.acc_y !== e.acc_y) begin
        $display("%0t: acc_y expected %h actual %h", $time, e.acc_y, r.acc_y);
        errors++;
      end
      if (r.saturated !== e.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                 r.saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    item_i;
  logic        res_valid_o;
  out_item_t   res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  grav_scoreboard sb;
  int             idle_cycles;
  bit             no_gaps;

  direct_sum_gravity_2d dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) sb.check_result(res_o);
      if (res_valid_o || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("direct_sum_gravity_2d verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(in_item_t it);
    if (!no_gaps && $urandom_range(99) < 26) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic load_body(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] m);
    in_item_t it;
    it.op         = OP_LOAD;
    it.body_index = idx[9:0];
    it.pos_x      = x;
    it.pos_y      = y;
    it.body_mass  = m;
    send_item(it);
  endtask

  task automatic query_body(int idx);
    in_item_t it;
    it.op         = OP_QUERY;
    it.body_index = idx[9:0];
    it.pos_x      = $urandom;
    it.pos_y      = $urandom;
    it.body_mass  = $urandom;
    send_item(it);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic reg_write(reg_e r, logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(r, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pos();
    return $urandom_range(1) ? $urandom : 32'($urandom_range(0, 32'h3FFFFF)) - 32'h200000;
  endfunction

  function automatic logic [31:0] rand_mass();
    return $urandom_range(1) ? $urandom : 32'($urandom_range(0, 32'h3FFFFF));
  endfunction

  initial begin
    int          done;
    int          cnt;
    logic [31:0] g;
    logic [31:0] s;
    sb          = new();
    idle_cycles = 0;
    no_gaps     = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    reg_write(REG_BODY_COUNT, 32'd4);
    reg_write(REG_GRAV, GRAV_RST);
    reg_write(REG_SOFT, SOFT_RST);
    load_body(0, 32'd0, 32'd0, 32'h00010000);
    load_body(1, POS_MAX, POS_MIN, ALL_ONES);
    load_body(2, 32'd0, 32'd0, 32'h00020000);
    load_body(3, 32'd1, 32'd0, ALL_ONES);
    load_body(1000, POS_MIN, POS_MAX, 32'd0);
    for (int i = 0; i < 4; i++) query_body(i);
    query_body(1000);
    wait_idle();
    reg_write(REG_SOFT, 32'd0);
    query_body(0);
    query_body(2);
    wait_idle();
    reg_write(REG_GRAV, ALL_ONES);
    query_body(3);
    query_body(1);
    wait_idle();
    reg_write(REG_BODY_COUNT, 32'd0);
    query_body(0);
    wait_idle();
    reg_write(REG_BODY_COUNT, 32'd1);
    query_body(0);

    no_gaps = 1'b1;
    for (int i = 0; i < FILL_BODIES; i++) load_body(i, rand_pos(), rand_pos(), rand_mass());
    no_gaps = 1'b0;
    wait_idle();
    reg_write(REG_GRAV, GRAV_RST);
    reg_write(REG_SOFT, ALL_ONES);
    reg_write(REG_BODY_COUNT, FILL_BODIES);
    query_body($urandom_range(0, FILL_BODIES - 1));
    wait_idle();
    reg_write(REG_SOFT, SOFT_RST);
    query_body(FILL_BODIES - 1);

    done = 0;
    while (done < RAND_ITEMS) begin
      wait_idle();
      cnt = $urandom_range(99) < 10 ? $urandom_range(0, 1) : $urandom_range(2, 8);
      case ($urandom_range(3))
        0: g = GRAV_RST;
        1: g = 32'd0;
        2: g = ALL_ONES;
        default: g = $urandom;
      endcase
      case ($urandom_range(3))
        0: s = SOFT_RST;
        1: s = 32'd0;
        2: s = ALL_ONES;
        default: s = $urandom;
      endcase
      reg_write(REG_BODY_COUNT, cnt);
      reg_write(REG_GRAV, g);
      reg_write(REG_SOFT, s);
      for (int i = 0; i < 40; i++) begin
        no_gaps = (done >= 200 && done < 300);
        if ($urandom_range(1)) begin
          load_body($urandom_range(99) < 80 ? $urandom_range(0, cnt + 3)
                                            : $urandom_range(0, NUM_BODIES - 1),
                    rand_pos(), rand_pos(), rand_mass());
        end else begin
          query_body($urandom_range(99) < 80 ? $urandom_range(0, cnt + 1)
                                             : $urandom_range(0, FILL_BODIES - 1));
        end
        done++;
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("direct_sum_gravity_2d verification clean");
    end else begin
      $display("direct_sum_gravity_2d verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/dsg_pkg.sv
hw/rtl/dsg_body_mem.sv
hw/rtl/dsg_isqrt.sv
hw/rtl/dsg_recip.sv
hw/rtl/dsg_pair.sv
hw/rtl/direct_sum_gravity_2d.sv
dv/tb.sv
